// ----- sv/dual_histogram_with_peak_macros.svh -----
// assertion macros for the histogram rtl, used by dhp_ctrl
// expects clk and rst_n in the scope of the module that uses them
`ifndef DUAL_HISTOGRAM_WITH_PEAK_MACROS_SVH
`define DUAL_HISTOGRAM_WITH_PEAK_MACROS_SVH

// same-cycle implication, checked outside reset
`define DHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DHP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dhp_pkg.sv -----
// shared types and constants for the dual histogram block
// no dependencies
`timescale 1ns / 1ps

package dhp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int BIN_IDX_W   = 12;
  localparam int COARSE_W    = 8;
  localparam int COARSE_BINS = 256;
  localparam int OUT_CNT_W   = 32;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CNT_W   = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST  = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST = 16'sd4095;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic prep;
    logic div_step;
    logic rd;
    logic upd;
    logic load_out;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic oor;
    logic div_last;
    logic sweep_last;
  } status_t;

endpackage

// ----- sv/dhp_datapath.sv -----
// datapath: range check, 8-step restoring divider, both count memories, peaks
// and the result register; depends on dhp_pkg
`timescale 1ns / 1ps

module dhp_datapath
  import dhp_pkg::*;
#(
  parameter int FINE_BINS  = 4096,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_op,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic [BIN_IDX_W-1:0]        in_bin_index,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SAMPLE_W-1:0]         cfg_data,
  input  cmd_t                        cmd,
  output status_t                     status,
  output logic [BIN_IDX_W-1:0]        origin_bin,
  output logic [COARSE_W-1:0]         equal_bin,
  output logic [OUT_CNT_W-1:0]        origin_count,
  output logic [OUT_CNT_W-1:0]        equal_count,
  output logic [OUT_CNT_W-1:0]        peak_origin,
  output logic [OUT_CNT_W-1:0]        peak_equal,
  output logic                        out_of_range
);

  localparam int FI_W  = $clog2(FINE_BINS);
  localparam int CLR_N = (FINE_BINS > COARSE_BINS) ? FINE_BINS : COARSE_BINS;
  localparam int CNT_W = $clog2(CLR_N);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_W:0]     FINE_LIM  = (SAMPLE_W+1)'(FINE_BINS);
  localparam logic [CNT_W-1:0]      CLR_LAST  = CNT_W'(CLR_N - 1);
  localparam logic [CNT_W:0]        FINE_END  = (CNT_W+1)'(FINE_BINS);
  localparam logic [CNT_W:0]        COARSE_END = (CNT_W+1)'(COARSE_BINS);
  localparam logic [BIN_IDX_W-1:0]  COARSE_TOP = BIN_IDX_W'(COARSE_BINS - 1);

  logic [COUNT_BITS-1:0] fine_mem   [FINE_BINS];
  logic [COUNT_BITS-1:0] coarse_mem [COARSE_BINS];

  logic signed [SAMPLE_W-1:0] range_low_r, range_high_r;
  op_t                        op_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [BIN_IDX_W-1:0]       bi_r;
  logic [SAMPLE_W-1:0]        fi_r, span_r, rem_r;
  logic                       oor_r;
  logic [COARSE_W-1:0]        num_lo_r, q_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;
  logic [CNT_W-1:0]           clr_cnt_r;
  logic [FI_W-1:0]            fine_addr_r;
  logic [COARSE_W-1:0]        coarse_addr_r;
  logic [COUNT_BITS-1:0]      fine_rd_r, coarse_rd_r;
  logic [COUNT_BITS-1:0]      fcnt_r, ccnt_r;
  logic [COUNT_BITS-1:0]      fine_peak_r, coarse_peak_r;

  logic [BIN_IDX_W-1:0]       origin_bin_r;
  logic [COARSE_W-1:0]        equal_bin_r;
  logic [OUT_CNT_W-1:0]       origin_count_r, equal_count_r;
  logic [OUT_CNT_W-1:0]       peak_origin_r, peak_equal_r;
  logic                       out_of_range_r;

  logic signed [SAMPLE_W:0]   off, span;
  logic                       oor_now;
  logic [SAMPLE_W+COARSE_W-1:0] numer;
  logic [SAMPLE_W:0]          trial, trial_sub;
  logic                       trial_ge;
  logic [COARSE_W-1:0]        ci;
  logic [FI_W-1:0]            fine_raddr;
  logic [COARSE_W-1:0]        coarse_raddr;
  logic                       bi_in_fine, bi_in_coarse;
  logic [COUNT_BITS-1:0]      fine_new, coarse_new;
  logic                       acc_op, read_op, res_ok;
  logic                       sweep_fine, sweep_coarse;

  // range check on the captured sample
  assign off  = {sample_r[SAMPLE_W-1], sample_r} - {range_low_r[SAMPLE_W-1], range_low_r};
  assign span = {range_high_r[SAMPLE_W-1], range_high_r}
              - {range_low_r[SAMPLE_W-1], range_low_r};
  assign oor_now = (sample_r < range_low_r) || (sample_r > range_high_r)
                || ($unsigned(off) >= FINE_LIM);

  // fi * 255 as a shift and subtract
  assign numer = {fi_r, {COARSE_W{1'b0}}} - {{COARSE_W{1'b0}}, fi_r};

  // one restoring division step; remainder stays below span
  assign trial     = {rem_r, num_lo_r[COARSE_W-1]};
  assign trial_sub = trial - {1'b0, span_r};
  assign trial_ge  = (trial >= {1'b0, span_r});

  assign ci = (span_r == '0) ? '0 : q_r;

  assign acc_op  = (op_r == OP_ACC);
  assign read_op = (op_r == OP_READ);
  assign res_ok  = read_op || (acc_op && !oor_r);

  assign bi_in_fine   = ({{(SAMPLE_W+1-BIN_IDX_W){1'b0}}, bi_r} < FINE_LIM);
  assign bi_in_coarse = (bi_r <= COARSE_TOP);

  assign fine_raddr   = read_op ? FI_W'(bi_r) : fi_r[FI_W-1:0];
  assign coarse_raddr = read_op ? bi_r[COARSE_W-1:0] : ci;

  assign fine_new   = (fine_rd_r == COUNT_MAX) ? fine_rd_r : fine_rd_r + 1'b1;
  assign coarse_new = (coarse_rd_r == COUNT_MAX) ? coarse_rd_r : coarse_rd_r + 1'b1;

  assign sweep_fine   = ({1'b0, clr_cnt_r} < FINE_END);
  assign sweep_coarse = ({1'b0, clr_cnt_r} < COARSE_END);

  assign status.op         = op_r;
  assign status.oor        = oor_now;
  assign status.div_last   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.sweep_last = (clr_cnt_r == CLR_LAST);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control-side counters and peaks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      div_cnt_r     <= '0;
      fine_peak_r   <= '0;
      coarse_peak_r <= '0;
    end else begin
      if (cmd.sweep) begin
        clr_cnt_r <= (clr_cnt_r == CLR_LAST) ? '0 : clr_cnt_r + 1'b1;
      end
      if (cmd.prep) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (cmd.accept && (op_t'(in_op) == OP_CLEAR)) begin
        fine_peak_r   <= '0;
        coarse_peak_r <= '0;
      end else if (cmd.upd && acc_op) begin
        if (fine_new > fine_peak_r) fine_peak_r <= fine_new;
        if (coarse_new > coarse_peak_r) coarse_peak_r <= coarse_new;
      end
    end
  end

  // word capture, range check and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= op_t'(in_op);
      sample_r <= in_sample;
      bi_r     <= in_bin_index;
    end
    if (cmd.check) begin
      fi_r   <= off[SAMPLE_W-1:0];
      span_r <= span[SAMPLE_W-1:0];
      oor_r  <= oor_now;
    end
    if (cmd.prep) begin
      rem_r    <= numer[SAMPLE_W+COARSE_W-1:COARSE_W];
      num_lo_r <= numer[COARSE_W-1:0];
    end else if (cmd.div_step) begin
      rem_r    <= trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      num_lo_r <= {num_lo_r[COARSE_W-2:0], 1'b0};
      q_r      <= {q_r[COARSE_W-2:0], trial_ge};
    end
  end

  // fine store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sweep && sweep_fine) begin
      fine_mem[clr_cnt_r[FI_W-1:0]] <= '0;
    end else if (cmd.upd && acc_op) begin
      fine_mem[fine_addr_r] <= fine_new;
    end
    if (cmd.rd) begin
      fine_rd_r   <= fine_mem[fine_raddr];
      fine_addr_r <= fine_raddr;
    end
  end

  // coarse store
  always_ff @(posedge clk) begin
    if (cmd.sweep && sweep_coarse) begin
      coarse_mem[clr_cnt_r[COARSE_W-1:0]] <= '0;
    end else if (cmd.upd && acc_op) begin
      coarse_mem[coarse_addr_r] <= coarse_new;
    end
    if (cmd.rd) begin
      coarse_rd_r   <= coarse_mem[coarse_raddr];
      coarse_addr_r <= coarse_raddr;
    end
  end

  // counts after update, or as read
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (acc_op) begin
        fcnt_r <= fine_new;
        ccnt_r <= coarse_new;
      end else begin
        fcnt_r <= bi_in_fine ? fine_rd_r : '0;
        ccnt_r <= bi_in_coarse ? coarse_rd_r : '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      origin_bin_r   <= res_ok ? (read_op ? bi_r : fi_r[BIN_IDX_W-1:0]) : '0;
      equal_bin_r    <= (res_ok && !(read_op && !bi_in_coarse)) ? coarse_addr_r : '0;
      origin_count_r <= res_ok ? OUT_CNT_W'(fcnt_r) : '0;
      equal_count_r  <= res_ok ? OUT_CNT_W'(ccnt_r) : '0;
      peak_origin_r  <= OUT_CNT_W'(fine_peak_r);
      peak_equal_r   <= OUT_CNT_W'(coarse_peak_r);
      out_of_range_r <= acc_op && oor_r;
    end
  end

  assign origin_bin   = origin_bin_r;
  assign equal_bin    = equal_bin_r;
  assign origin_count = origin_count_r;
  assign equal_count  = equal_count_r;
  assign peak_origin  = peak_origin_r;
  assign peak_equal   = peak_equal_r;
  assign out_of_range = out_of_range_r;

endmodule

// ----- sv/dhp_ctrl.sv -----
// controller: sequences check, divide, memory read-modify-write, clearing
// sweep and the result handshake; depends on dhp_pkg and the macro header
`timescale 1ns / 1ps
`include "dual_histogram_with_peak_macros.svh"

module dhp_ctrl
  import dhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [1:0] in_op,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_ACC:   state_nxt = ST_CHECK;
            OP_READ:  state_nxt = ST_RD;
            OP_CLEAR: state_nxt = ST_RESP;
            OP_NOP:   state_nxt = ST_RESP;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_CHECK: state_nxt = status.oor ? ST_RESP : ST_PREP;
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = (status.op == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK: cmd.check = 1'b1;
      ST_PREP:  cmd.prep = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_RD:    cmd.rd = 1'b1;
      ST_UPD:   cmd.upd = 1'b1;
      ST_RESP:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `DHP_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command at once")
  `DHP_ASSERT_IMP(a_upd_after_rd, cmd.upd, $past(cmd.rd), "update without a memory read before it")
  `DHP_ASSERT_IMP(a_rd_after_div, cmd.rd && (status.op == OP_ACC), $past(cmd.div_step && status.div_last), "accumulate read before the divide finished")
  `DHP_ASSERT_NXT(a_sweep_end, cmd.sweep && status.sweep_last, state_r == ST_IDLE, "clearing sweep did not return to idle")

endmodule

// ----- sv/dual_histogram_with_peak.sv -----
// Dual histogram with running peaks.
// Input channel (in_valid/in_ready): one word = op, sample, bin_index.
//   op 0 counts a sample into the full-resolution store at sample - range_low
//   and into the 256-bin store at (sample - range_low) * 255 / span,
//   op 1 reads a bin, op 2 clears both stores and peaks, op 3 does nothing.
// Output channel (out_valid/out_ready): exactly one result word per input word.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 range_low,
//   index 1 range_high; write only while the block is idle.
// Accumulate runs range check, fi*255 setup, the restoring divider, then read
//   and write of both memories before its result; a read goes to the memory
//   read, a rejected sample leaves after the check, clear and op 3 go straight to the result.
// One word is in flight at a time; the next word is taken once its result sits in
//   the output register (after a clear, once the sweep ends), so a stalled
//   receiver only holds the block once a second result is ready.
// Clear and reset run a sweep over max(FINE_BINS, 256) entries of both
//   memories, one entry a cycle, during which in_ready is low.
// Reset (rst_n low, synchronous) also zeroes peaks and restores the range.
// Depends on dhp_pkg, dhp_ctrl and dhp_datapath.
`timescale 1ns / 1ps

module dual_histogram_with_peak
  import dhp_pkg::*;
#(
  parameter int FINE_BINS  = 4096,
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [BIN_IDX_W-1:0]       in_bin_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [BIN_IDX_W-1:0]       out_origin_bin,
  output logic [COARSE_W-1:0]        out_equal_bin,
  output logic [OUT_CNT_W-1:0]       out_origin_count,
  output logic [OUT_CNT_W-1:0]       out_equal_count,
  output logic [OUT_CNT_W-1:0]       out_peak_origin,
  output logic [OUT_CNT_W-1:0]       out_peak_equal,
  output logic                       out_out_of_range,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  dhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dhp_datapath #(
    .FINE_BINS  (FINE_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_sample    (in_sample),
    .in_bin_index (in_bin_index),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .origin_bin   (out_origin_bin),
    .equal_bin    (out_equal_bin),
    .origin_count (out_origin_count),
    .equal_count  (out_equal_count),
    .peak_origin  (out_peak_origin),
    .peak_equal   (out_peak_equal),
    .out_of_range (out_out_of_range)
  );

endmodule

// ----- verif/dual_histogram_with_peak_test.sv -----
// self-checking testbench for dual_histogram_with_peak: directed and random words,
// random stalls on both channels, results compared against a behavioral histogram
// depends on dhp_pkg and the dual_histogram_with_peak rtl
`timescale 1ns / 1ps

module dual_histogram_with_peak_test;
  import dhp_pkg::*;

  localparam int FINE_BINS  = 4096;
  localparam int WDOG_LIMIT = 20000;
  localparam int SHOW_MAX   = 10;
  localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

  typedef struct {
    op_t                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BIN_IDX_W-1:0]      bin_index;
  } hist_word_t;

  typedef struct {
    logic [BIN_IDX_W-1:0] origin_bin;
    logic [COARSE_W-1:0]  equal_bin;
    logic [OUT_CNT_W-1:0] origin_count;
    logic [OUT_CNT_W-1:0] equal_count;
    logic [OUT_CNT_W-1:0] peak_origin;
    logic [OUT_CNT_W-1:0] peak_equal;
    logic                 out_of_range;
  } hist_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_op = OP_NOP;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic [BIN_IDX_W-1:0]        in_bin_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [BIN_IDX_W-1:0]        out_origin_bin;
  logic [COARSE_W-1:0]         out_equal_bin;
  logic [OUT_CNT_W-1:0]        out_origin_count;
  logic [OUT_CNT_W-1:0]        out_equal_count;
  logic [OUT_CNT_W-1:0]        out_peak_origin;
  logic [OUT_CNT_W-1:0]        out_peak_equal;
  logic                        out_out_of_range;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_RANGE_LOW;
  logic [SAMPLE_W-1:0]         cfg_data = '0;

  // behavioral copy of the block state
  logic [OUT_CNT_W-1:0]        fine_tally [FINE_BINS];
  logic [OUT_CNT_W-1:0]        coarse_tally [COARSE_BINS];
  logic [OUT_CNT_W-1:0]        fine_top;
  logic [OUT_CNT_W-1:0]        coarse_top;
  logic signed [SAMPLE_W-1:0]  lim_lo = RANGE_LOW_RST;
  logic signed [SAMPLE_W-1:0]  lim_hi = RANGE_HIGH_RST;

  hist_word_t   word_queue[$];
  hist_result_t due_results[$];
  int           fail_cnt = 0;
  int           idle_cycles = 0;
  bit           in_taken = 1'b0;
  bit           calm = 1'b0;
  bit           rx_long_req = 1'b0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_long_left = 0;

  dual_histogram_with_peak i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_origin_bin   (out_origin_bin),
    .out_equal_bin    (out_equal_bin),
    .out_origin_count (out_origin_count),
    .out_equal_count  (out_equal_count),
    .out_peak_origin  (out_peak_origin),
    .out_peak_equal   (out_peak_equal),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void wipe_tallies();
    foreach (fine_tally[i]) fine_tally[i] = '0;
    foreach (coarse_tally[i]) coarse_tally[i] = '0;
    fine_top   = '0;
    coarse_top = '0;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] bump(logic [OUT_CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // applies one word to the histogram copy and returns the result it must produce
  function automatic hist_result_t tally_word(hist_word_t w);
    hist_result_t r;
    int s, lo, hi, off, span, fi, ci;
    r = '{default: 0};
    s    = int'(w.sample);
    lo   = int'(lim_lo);
    hi   = int'(lim_hi);
    off  = s - lo;
    span = hi - lo;
    case (w.op)
      OP_ACC: begin
        if (s < lo || s > hi || off >= FINE_BINS) begin
          r.out_of_range = 1'b1;
        end else begin
          fi = off;
          ci = (span > 0) ? (fi * 255) / span : 0;
          ci = ci & 255;
          fine_tally[fi]   = bump(fine_tally[fi]);
          coarse_tally[ci] = bump(coarse_tally[ci]);
          if (fine_tally[fi] > fine_top) fine_top = fine_tally[fi];
          if (coarse_tally[ci] > coarse_top) coarse_top = coarse_tally[ci];
          r.origin_bin   = BIN_IDX_W'(fi);
          r.equal_bin    = COARSE_W'(ci);
          r.origin_count = fine_tally[fi];
          r.equal_count  = coarse_tally[ci];
        end
      end
      OP_READ: begin
        r.origin_bin = w.bin_index;
        if (w.bin_index < FINE_BINS) r.origin_count = fine_tally[w.bin_index];
        if (w.bin_index < COARSE_BINS) begin
          r.equal_bin   = w.bin_index[COARSE_W-1:0];
          r.equal_count = coarse_tally[w.bin_index];
        end
      end
      OP_CLEAR: wipe_tallies();
      default: ;
    endcase
    if (w.op != OP_CLEAR) begin
      r.peak_origin = fine_top;
      r.peak_equal  = coarse_top;
    end
    return r;
  endfunction

  // input acceptance and output checking
  always @(posedge clk) begin
    hist_word_t   w;
    hist_result_t want;
    if (rst_n && in_valid && in_ready) begin
      w.op        = op_t'(in_op);
      w.sample    = in_sample;
      w.bin_index = in_bin_index;
      due_results.push_back(tally_word(w));
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_MAX)
          $display("unexpected result word: bin %0d/%0d count %0d/%0d",
                   out_origin_bin, out_equal_bin, out_origin_count, out_equal_count);
      end else begin
        want = due_results.pop_front();
        if (want.origin_bin !== out_origin_bin || want.equal_bin !== out_equal_bin ||
            want.origin_count !== out_origin_count ||
            want.equal_count !== out_equal_count ||
            want.peak_origin !== out_peak_origin || want.peak_equal !== out_peak_equal ||
            want.out_of_range !== out_out_of_range) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_MAX)
            $display({"result mismatch: exp bin %0d/%0d cnt %0d/%0d peak %0d/%0d oor %0b",
                      " | got bin %0d/%0d cnt %0d/%0d peak %0d/%0d oor %0b"},
                     want.origin_bin, want.equal_bin, want.origin_count,
                     want.equal_count, want.peak_origin, want.peak_equal,
                     want.out_of_range, out_origin_bin, out_equal_bin,
                     out_origin_count, out_equal_count, out_peak_origin,
                     out_peak_equal, out_out_of_range);
        end
      end
    end
  end

  // sender: offers the queued words with random gaps
  always @(negedge clk) begin
    hist_word_t nx;
    logic       v;
    v = in_valid;
    if (in_taken) begin
      v        = 1'b0;
      in_taken = 1'b0;
    end
    if (rst_n && !v) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        tx_gap = $urandom_range(0, 18);
      end else if (word_queue.size() != 0) begin
        nx = word_queue.pop_front();
        in_op        <= nx.op;
        in_sample    <= nx.sample;
        in_bin_index <= nx.bin_index;
        v = 1'b1;
      end
    end
    in_valid <= v;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rx_long_left > 0) begin
      rx_long_left--;
    end else if (rx_long_req) begin
      rx_long_req  = 1'b0;
      rx_long_left = 299;
    end else if (rx_gap > 0) begin
      rx_gap--;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      rx_gap = $urandom_range(0, 18);
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  // a clear sweep keeps in_ready low but ends well under the watchdog limit
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
      $display("** dual_histogram_with_peak: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(op_t op, int s, int b);
    hist_word_t w;
    w.op        = op;
    w.sample    = SAMPLE_W'(s);
    w.bin_index = BIN_IDX_W'(b);
    word_queue.push_back(w);
  endtask

  // mostly in-range samples with a few hot values so peaks climb
  task automatic push_random_words(int n);
    int top, room, pick, off;
    for (int k = 0; k < n; k++) begin
      top  = (int'(lim_hi) < int'(lim_lo) + FINE_BINS - 1) ? int'(lim_hi)
                                                           : int'(lim_lo) + FINE_BINS - 1;
      room = top - int'(lim_lo);
      pick = $urandom_range(0, 99);
      if (pick < 65 && room >= 0) begin
        if ($urandom_range(0, 1) == 0) off = $urandom_range(0, room);
        else off = $urandom_range(0, (room < 7) ? room : 7);
        push_word(OP_ACC, int'(lim_lo) + off, $urandom);
      end else if (pick < 72) begin
        push_word(OP_ACC, $urandom, $urandom);
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) == 0) push_word(OP_READ, $urandom, $urandom);
        else push_word(OP_READ, $urandom, $urandom_range(0, 300));
      end else if (pick < 98) begin
        push_word(OP_NOP, $urandom, $urandom);
      end else begin
        push_word(OP_CLEAR, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (word_queue.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SAMPLE_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_RANGE_LOW) lim_lo = SAMPLE_W'(val);
    else lim_hi = SAMPLE_W'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_range(int lo, int hi);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
  endtask

  initial begin
    int lo_set [11];
    int hi_set [11];
    wipe_tallies();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default range 0..4095: edges, rejects, reads past the coarse store, clear
    push_word(OP_ACC, 0, 0);
    push_word(OP_ACC, 4095, 4095);
    push_word(OP_ACC, 4096, 0);
    push_word(OP_ACC, -1, 0);
    push_word(OP_ACC, -32768, 0);
    push_word(OP_ACC, 32767, 4095);
    push_word(OP_ACC, 16'sh5555, 12'haaa);
    push_word(OP_ACC, 2048, 0);
    push_word(OP_ACC, 2048, 0);
    push_word(OP_ACC, 2049, 0);
    push_word(OP_READ, 0, 0);
    push_word(OP_READ, 0, 2048);
    push_word(OP_READ, -1, 4095);
    push_word(OP_READ, 0, 255);
    push_word(OP_READ, 0, 256);
    push_word(OP_READ, 0, 127);
    push_word(OP_NOP, -1, 4095);
    push_word(OP_CLEAR, 0, 0);
    push_word(OP_READ, 0, 2048);
    push_word(OP_READ, 0, 127);
    push_word(OP_ACC, 4095, 0);
    push_word(OP_READ, 0, 255);
    wait_drained();
    repeat (20) @(posedge clk);

    lo_set = '{-32768, 100, 500, 32767, -2000, 0, -100, 0, 0, -32768, 0};
    hi_set = '{32767, 100, 10, 32767, 2095, 255, 5000, 0, 0, -28673, 4095};
    for (int p = 0; p < 11; p++) begin
      if (p == 7 || p == 8) begin
        lo_set[p] = int'($urandom_range(0, 65535)) - 32768;
        hi_set[p] = lo_set[p] + int'($urandom_range(0, 6000));
        if (hi_set[p] > 32767) hi_set[p] = 32767;
      end
      calm = (p == 10);
      set_range(lo_set[p], hi_set[p]);
      // long receiver hold-off while the sender keeps offering words
      if (p == 4) rx_long_req = 1'b1;
      push_random_words(18);
      // sender waits for every result before going on
      if (p == 5) wait_drained();
      push_random_words(18);
      wait_drained();
      repeat (20) @(posedge clk);
    end

    repeat (30) @(posedge clk);
    if (due_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("** dual_histogram_with_peak: PASSED **");
    end else begin
      $display("** dual_histogram_with_peak: FAILED **");
    end
    $finish;
  end

endmodule
